### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define PTT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptt assertion failed");

// condition implies consequence in the next cycle
`define PTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptt assertion failed");

`endif

### hdl/ptt_pkg.sv
// types, codes and constants of the periodic task tick table
`default_nettype none

package ptt_pkg;

   localparam int MAX_TASKS_DEFAULT = 16;
   localparam int RESULT_ROOM       = 16;
   localparam int FIRE_CNT_W        = $clog2(RESULT_ROOM + 1);
   localparam int CMD_DEPTH         = 2;
   localparam int RSP_DEPTH         = 4;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [2:0] KIND_FIRED    = 3'd0;
   localparam logic [2:0] KIND_ADDED    = 3'd1;
   localparam logic [2:0] KIND_FULL     = 3'd2;
   localparam logic [2:0] KIND_REMOVED  = 3'd3;
   localparam logic [2:0] KIND_BAD_SLOT = 3'd4;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_ADD,
      CMD_REMOVE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [7:0]  task_id;
      logic [31:0] period;
      logic [3:0]  slot;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  task_id;
      logic [31:0] period;
      logic [31:0] elapsed;
   } entry_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] fired_id;
      logic [3:0] slot;
      logic [4:0] entries;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_FLUSH,
      BK_SINGLE
   } back_state_type;

endpackage

`default_nettype wire

### hdl/periodic_task_tick_table.sv
// top level of the periodic task tick table
//
//   channel  ports   handshake          contents
//   request  req_*   push / full        opcode, task_id, period_ticks, slot_index
//   response rsp_*   pop / empty        kind, fired_id, slot, entries, last
//
// back end: adds, rejected requests and tail removes answer without a table walk; other
// removes walk from slot_index + 1 to the tail, ticks walk every entry; one ram entry per cycle while not stalled
// reset is synchronous and leaves the table empty; the ram is never cleared
// a two entry request queue and a four entry response queue decouple the
// table walk from both sides; a full response queue stalls the tick walk
`default_nettype none

module periodic_task_tick_table
   import ptt_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_task_id,
   input  wire logic [31:0] req_period_ticks,
   input  wire logic [3:0]  req_slot_index,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_fired_id,
   output logic [3:0]       rsp_slot,
   output logic [4:0]       rsp_entries,
   output logic             rsp_last
);

   localparam int RSP_W = $bits(rsp_type);

   logic             cmd_valid;
   cmd_type          cmd_data;
   logic             cmd_pop;
   logic             rq_full;
   logic             rq_push;
   rsp_type          rq_wr_data;
   logic [RSP_W-1:0] rq_rd_raw;
   rsp_type          rq_rd_data;

   ptt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_opcode       (req_opcode),
      .req_task_id      (req_task_id),
      .req_period_ticks (req_period_ticks),
      .req_slot_index   (req_slot_index),
      .req_full         (req_full),
      .cmd_valid        (cmd_valid),
      .cmd_data         (cmd_data),
      .cmd_pop          (cmd_pop)
   );

   ptt_back #(
      .MAX_TASKS (MAX_TASKS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rq_full),
      .rsp_push  (rq_push),
      .rsp_data  (rq_wr_data)
   );

   ptt_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rq_push),
      .wr_data (rq_wr_data),
      .full    (rq_full),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rq_rd_raw)
   );

   assign rq_rd_data   = rsp_type'(rq_rd_raw);
   assign rsp_kind     = rq_rd_data.kind;
   assign rsp_fired_id = rq_rd_data.fired_id;
   assign rsp_slot     = rq_rd_data.slot;
   assign rsp_entries  = rq_rd_data.entries;
   assign rsp_last     = rq_rd_data.last;

endmodule

`default_nettype wire

### hdl/ptt_ram.sv
// generic single write port ram with registered read
`default_nettype none

module ptt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/ptt_fifo.sv
// small register fifo used for the request and response queues
`default_nettype none

module ptt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### hdl/ptt_front.sv
// front end: takes requests, decodes the opcode, drops unknown opcodes and queues commands
`default_nettype none

module ptt_front
   import ptt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_task_id,
   input  wire logic [31:0] req_period_ticks,
   input  wire logic [3:0]  req_slot_index,
   output logic             req_full,
   output logic             cmd_valid,
   output cmd_type          cmd_data,
   input  wire logic        cmd_pop
);

   localparam int CMD_W = $bits(cmd_type);

   cmd_type          dec_cmd;
   logic             dec_keep;
   logic [CMD_W-1:0] q_rd_data;
   logic             q_empty;

   always_comb begin
      dec_cmd.task_id = req_task_id;
      dec_cmd.period  = req_period_ticks;
      dec_cmd.slot    = req_slot_index;
      dec_cmd.op      = CMD_TICK;
      dec_keep        = 1'b1;
      case (req_opcode)
         OP_TICK:   dec_cmd.op = CMD_TICK;
         OP_ADD:    dec_cmd.op = CMD_ADD;
         OP_REMOVE: dec_cmd.op = CMD_REMOVE;
         default:   dec_keep   = 1'b0;
      endcase
   end

   ptt_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push & dec_keep),
      .wr_data (dec_cmd),
      .full    (req_full),
      .pop     (cmd_pop),
      .empty   (q_empty),
      .rd_data (q_rd_data)
   );

   assign cmd_valid = ~q_empty;
   assign cmd_data  = cmd_type'(q_rd_data);

endmodule

`default_nettype wire

### hdl/ptt_back.sv
// back end: walks the task table for ticks and for removes below the tail, appends on adds
`default_nettype none

module ptt_back
   import ptt_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd_data,
   output logic         cmd_pop,
   input  wire logic    rsp_full,
   output logic         rsp_push,
   output rsp_type      rsp_data
);

   localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W   = $clog2(MAX_TASKS + 1);
   localparam int CMP_W   = CNT_W + 4;
   localparam int ENTRY_W = $bits(entry_type);

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              scan_rm_ff, scan_rm_in;
   logic              pend_vld_ff, pend_vld_in;
   rsp_type           pend_ff, pend_in;
   rsp_type           single_ff, single_in;
   logic [FIRE_CNT_W-1:0] fire_cnt_ff, fire_cnt_in;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   entry_type          ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_raw;
   entry_type          entry;

   logic [31:0]        elapsed_inc;
   logic               fire;
   logic               record;
   logic               scan_last;
   logic               stall;
   logic [IDX_W+3:0]   idx_wide;
   logic [CNT_W+4:0]   cnt_wide;
   logic [CMP_W-1:0]   slot_ext;
   logic [CMP_W-1:0]   count_cmp;
   logic               slot_bad;
   logic               rm_tail;
   logic               table_full;
   logic [IDX_W-1:0]   start_idx;

   assign entry       = entry_type'(ram_rd_raw);
   assign elapsed_inc = entry.elapsed + 32'd1;
   assign fire        = (elapsed_inc >= entry.period);
   assign record      = fire && (fire_cnt_ff < FIRE_CNT_W'(RESULT_ROOM));
   assign scan_last   = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign stall       = ~scan_rm_ff & record & pend_vld_ff & rsp_full;
   assign idx_wide    = {4'b0, idx_ff};
   assign cnt_wide    = {5'b0, count_ff};
   assign slot_ext    = {CNT_W'(0), cmd_data.slot};
   assign count_cmp   = {4'b0, count_ff};
   assign slot_bad    = (slot_ext >= count_cmp);
   assign rm_tail     = ((slot_ext + CMP_W'(1)) == count_cmp);
   assign table_full  = (count_ff == CNT_W'(MAX_TASKS));
   assign start_idx   = slot_ext[IDX_W-1:0] + IDX_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               case (cmd_data.op)
                  CMD_TICK: begin
                     if (count_ff != '0) begin
                        state_in = BK_SCAN;
                     end
                  end
                  CMD_ADD: state_in = BK_SINGLE;
                  CMD_REMOVE: begin
                     if (slot_bad || rm_tail) begin
                        state_in = BK_SINGLE;
                     end else begin
                        state_in = BK_SCAN;
                     end
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_SCAN: begin
            if (!stall && scan_last) begin
               state_in = scan_rm_ff ? BK_SINGLE : BK_FLUSH;
            end
         end
         BK_FLUSH: begin
            if (!pend_vld_ff || !rsp_full) begin
               state_in = BK_IDLE;
            end
         end
         BK_SINGLE: begin
            if (!rsp_full) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and handshakes
   always_comb begin
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp_data    = '0;
      count_in    = count_ff;
      idx_in      = idx_ff;
      scan_rm_in  = scan_rm_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      single_in   = single_ff;
      fire_cnt_in = fire_cnt_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = entry;
      ram_rd_addr = idx_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd_data.op)
                  CMD_TICK: begin
                     idx_in      = '0;
                     ram_rd_addr = '0;
                     scan_rm_in  = 1'b0;
                     pend_vld_in = 1'b0;
                     fire_cnt_in = '0;
                  end
                  CMD_ADD: begin
                     single_in = '0;
                     if (table_full) begin
                        single_in.kind = KIND_FULL;
                     end else begin
                        ram_wr_en           = 1'b1;
                        ram_wr_addr         = count_ff[IDX_W-1:0];
                        ram_wr_data.task_id = cmd_data.task_id;
                        ram_wr_data.period  = cmd_data.period;
                        ram_wr_data.elapsed = '0;
                        count_in            = count_ff + CNT_W'(1);
                        single_in.kind      = KIND_ADDED;
                        single_in.slot      = cnt_wide[3:0];
                     end
                  end
                  CMD_REMOVE: begin
                     single_in      = '0;
                     single_in.slot = cmd_data.slot;
                     if (slot_bad) begin
                        single_in.kind = KIND_BAD_SLOT;
                     end else begin
                        single_in.kind = KIND_REMOVED;
                        if (rm_tail) begin
                           count_in = count_ff - CNT_W'(1);
                        end else begin
                           idx_in      = start_idx;
                           ram_rd_addr = start_idx;
                           scan_rm_in  = 1'b1;
                        end
                     end
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         BK_SCAN: begin
            if (scan_rm_ff) begin
               // move entry down by one slot
               ram_wr_en   = 1'b1;
               ram_wr_addr = idx_ff - IDX_W'(1);
               ram_wr_data = entry;
               if (scan_last) begin
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  idx_in      = idx_ff + IDX_W'(1);
                  ram_rd_addr = idx_ff + IDX_W'(1);
               end
            end else if (!stall) begin
               ram_wr_en           = 1'b1;
               ram_wr_addr         = idx_ff;
               ram_wr_data         = entry;
               ram_wr_data.elapsed = fire ? 32'd0 : elapsed_inc;
               if (record) begin
                  if (pend_vld_ff) begin
                     rsp_push         = 1'b1;
                     rsp_data         = pend_ff;
                     rsp_data.entries = cnt_wide[4:0];
                     rsp_data.last    = 1'b0;
                  end
                  pend_vld_in      = 1'b1;
                  pend_in          = '0;
                  pend_in.kind     = KIND_FIRED;
                  pend_in.fired_id = entry.task_id;
                  pend_in.slot     = idx_wide[3:0];
                  fire_cnt_in      = fire_cnt_ff + FIRE_CNT_W'(1);
               end
               if (!scan_last) begin
                  idx_in      = idx_ff + IDX_W'(1);
                  ram_rd_addr = idx_ff + IDX_W'(1);
               end
            end
         end
         BK_FLUSH: begin
            if (pend_vld_ff && !rsp_full) begin
               rsp_push         = 1'b1;
               rsp_data         = pend_ff;
               rsp_data.entries = cnt_wide[4:0];
               rsp_data.last    = 1'b1;
               pend_vld_in      = 1'b0;
            end
         end
         BK_SINGLE: begin
            if (!rsp_full) begin
               rsp_push         = 1'b1;
               rsp_data         = single_ff;
               rsp_data.entries = cnt_wide[4:0];
               rsp_data.last    = 1'b1;
            end
         end
         default: cmd_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         count_ff    <= '0;
         pend_vld_ff <= 1'b0;
         scan_rm_ff  <= 1'b0;
         fire_cnt_ff <= '0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pend_vld_ff <= pend_vld_in;
         scan_rm_ff  <= scan_rm_in;
         fire_cnt_ff <= fire_cnt_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff   <= pend_in;
      single_ff <= single_in;
   end

   ptt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

endmodule

`default_nettype wire

### hdl/ptt_checker.sv
// port level checks for the periodic task tick table, bound to the top
`default_nettype none

`include "assert_macros.svh"

module ptt_checker
   import ptt_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [2:0]  rsp_kind,
   input wire logic [7:0]  rsp_fired_id,
   input wire logic [3:0]  rsp_slot,
   input wire logic [4:0]  rsp_entries,
   input wire logic        rsp_last
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam logic [CNT_W+4:0] MAX_WIDE = (CNT_W + 5)'(MAX_TASKS);

   logic [CNT_W+4:0] entries_wide;

   assign entries_wide = {CNT_W'(0), rsp_entries};

   `PTT_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_kind) && $stable(rsp_fired_id) && $stable(rsp_slot) && $stable(rsp_entries) && $stable(rsp_last))
   `PTT_ASSERT_SAME(a_kind_known, clock, reset, !rsp_empty, rsp_kind == KIND_FIRED || rsp_kind == KIND_ADDED || rsp_kind == KIND_FULL || rsp_kind == KIND_REMOVED || rsp_kind == KIND_BAD_SLOT)
   `PTT_ASSERT_SAME(a_id_only_on_fire, clock, reset, !rsp_empty && rsp_kind != KIND_FIRED, rsp_fired_id == 8'd0 && rsp_last)
   `PTT_ASSERT_SAME(a_entries_bound, clock, reset, !rsp_empty && MAX_WIDE < 6'd32, entries_wide <= MAX_WIDE)
   `PTT_ASSERT_SAME(a_full_means_max, clock, reset, !rsp_empty && rsp_kind == KIND_FULL, entries_wide == MAX_WIDE && rsp_slot == 4'd0)

endmodule

bind periodic_task_tick_table ptt_checker #(
   .MAX_TASKS (MAX_TASKS)
) u_ptt_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_empty    (rsp_empty),
   .rsp_pop      (rsp_pop),
   .rsp_kind     (rsp_kind),
   .rsp_fired_id (rsp_fired_id),
   .rsp_slot     (rsp_slot),
   .rsp_entries  (rsp_entries),
   .rsp_last     (rsp_last)
);

`default_nettype wire

### test/periodic_task_tick_table_test.sv
// self-checking testbench of the periodic task tick table with a shadow table scoreboard
`timescale 1ns / 100ps

module periodic_task_tick_table_test;
   import ptt_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 280;
   localparam int PAUSE_AT = 140;
   localparam int STALL_MAX = 13;
   localparam int IDLE_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 40;

   class tick_table_shadow;
      logic [7:0] ids [MAX_TASKS_DEFAULT];
      logic [31:0] periods [MAX_TASKS_DEFAULT];
      logic [31:0] elapsed [MAX_TASKS_DEFAULT];
      int count;
      rsp_type pending_rsp [$];
      int errors;
      int requests;
      int kind_seen [5];

      function new();
         count = 0;
         errors = 0;
         requests = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
      endfunction

      function void push_rsp(logic [2:0] kind, logic [7:0] id, logic [3:0] slot);
         rsp_type r;
         r.kind = kind;
         r.fired_id = id;
         r.slot = slot;
         r.entries = 5'(count);
         r.last = 1'b1;
         pending_rsp.push_back(r);
      endfunction

      function void apply_request(logic [1:0] op, logic [7:0] id, logic [31:0] period,
                                  logic [3:0] slot);
         int fired;
         requests++;
         case (op)
            OP_TICK: begin
               fired = 0;
               for (int i = 0; i < count; i++) begin
                  elapsed[i] = elapsed[i] + 32'd1;
                  if (elapsed[i] >= periods[i]) begin
                     elapsed[i] = '0;
                     if (fired > 0) pending_rsp[pending_rsp.size() - 1].last = 1'b0;
                     push_rsp(KIND_FIRED, ids[i], 4'(i));
                     fired++;
                  end
               end
            end
            OP_ADD: begin
               if (count >= MAX_TASKS_DEFAULT) begin
                  push_rsp(KIND_FULL, 8'd0, 4'd0);
               end else begin
                  ids[count] = id;
                  periods[count] = period;
                  elapsed[count] = '0;
                  count++;
                  push_rsp(KIND_ADDED, 8'd0, 4'(count - 1));
               end
            end
            OP_REMOVE: begin
               if (int'(slot) >= count) begin
                  push_rsp(KIND_BAD_SLOT, 8'd0, slot);
               end else begin
                  for (int i = int'(slot); i + 1 < count; i++) begin
                     ids[i] = ids[i + 1];
                     periods[i] = periods[i + 1];
                     elapsed[i] = elapsed[i + 1];
                  end
                  count--;
                  push_rsp(KIND_REMOVED, 8'd0, slot);
               end
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(logic [2:0] kind, logic [7:0] id, logic [3:0] slot,
                          logic [4:0] entries, logic last);
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         e = pending_rsp.pop_front();
         if (e.kind <= KIND_BAD_SLOT) kind_seen[e.kind]++;
         if (kind !== e.kind)
            report_mismatch($sformatf("kind %0d, wanted %0d", kind, e.kind));
         if (id !== e.fired_id)
            report_mismatch($sformatf("fired_id %0d, wanted %0d", id, e.fired_id));
         if (slot !== e.slot)
            report_mismatch($sformatf("slot %0d, wanted %0d", slot, e.slot));
         if (entries !== e.entries)
            report_mismatch($sformatf("entries %0d, wanted %0d", entries, e.entries));
         if (last !== e.last)
            report_mismatch($sformatf("last %0b, wanted %0b", last, e.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic [1:0] req_opcode = OP_TICK;
   logic [7:0] req_task_id = '0;
   logic [31:0] req_period_ticks = '0;
   logic [3:0] req_slot_index = '0;
   logic rsp_pop = 1'b0;
   logic req_full;
   logic rsp_empty;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_fired_id;
   logic [3:0] rsp_slot;
   logic [4:0] rsp_entries;
   logic rsp_last;

   tick_table_shadow table_shadow = new();
   bit send_idles = 1'b1;
   bit pop_idles = 1'b1;
   int idle_cycles = 0;

   periodic_task_tick_table dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_opcode(req_opcode),
      .req_task_id(req_task_id),
      .req_period_ticks(req_period_ticks),
      .req_slot_index(req_slot_index),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_kind(rsp_kind),
      .rsp_fired_id(rsp_fired_id),
      .rsp_slot(rsp_slot),
      .rsp_entries(rsp_entries),
      .rsp_last(rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [7:0] id,
                               input logic [31:0] period, input logic [3:0] slot);
      int gap;
      gap = send_idles ? $urandom_range(0, STALL_MAX) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_opcode <= op;
      req_task_id <= id;
      req_period_ticks <= period;
      req_slot_index <= slot;
      do @(posedge clock); while (req_full);
      table_shadow.apply_request(op, id, period, slot);
      if ($urandom_range(0, 24) == 0) send_idles = !send_idles;
   endtask

   task automatic take_responses();
      int gap;
      forever begin
         gap = pop_idles ? $urandom_range(0, STALL_MAX) : 0;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         table_shadow.check_response(rsp_kind, rsp_fired_id, rsp_slot, rsp_entries,
                                     rsp_last);
         if ($urandom_range(0, 24) == 0) pop_idles = !pop_idles;
      end
   endtask

   function automatic logic [31:0] draw_period();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick <= 5) return 32'($urandom_range(0, 6));
      if (pick <= 7) return 32'($urandom_range(7, 40));
      return $urandom;
   endfunction

   task automatic send_random();
      int pick;
      int sent;
      logic [3:0] slot;
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         if (sent == PAUSE_AT) begin
            // hold off until the response side is fully drained
            req_push <= 1'b0;
            while (table_shadow.pending_rsp.size() != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         if (table_shadow.count > 0 && $urandom_range(0, 4) != 0)
            slot = 4'($urandom_range(0, table_shadow.count - 1));
         else
            slot = 4'($urandom_range(0, 15));
         if (pick < 45) begin
            send_request(OP_TICK, 8'($urandom), $urandom, 4'($urandom));
            sent++;
         end else if (pick < 72) begin
            send_request(OP_ADD, 8'($urandom_range(0, 255)), draw_period(),
                         4'($urandom));
            sent++;
         end else if (pick < 95) begin
            send_request(OP_REMOVE, 8'($urandom), $urandom, slot);
            sent++;
         end else begin
            send_request(OP_UNUSED, 8'($urandom), $urandom, 4'($urandom));
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      fork
         take_responses();
      join_none

      // empty table corners
      send_request(OP_TICK, 8'd0, 32'd0, 4'd0);
      send_request(OP_REMOVE, 8'd0, 32'd0, 4'd0);
      // field extremes
      send_request(OP_ADD, 8'd0, 32'd0, 4'd0);
      send_request(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 4'hF);
      send_request(OP_ADD, 8'hA5, 32'd2, 4'd0);
      send_request(OP_TICK, 8'd0, 32'd0, 4'd0);
      send_request(OP_TICK, 8'd0, 32'd0, 4'd0);
      send_request(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 4'hF);
      send_request(OP_REMOVE, 8'd0, 32'd0, 4'd1);
      send_request(OP_REMOVE, 8'd0, 32'd0, 4'd5);
      // fill the table, overflow it and fire the entries of period zero
      for (int k = 0; k < MAX_TASKS_DEFAULT - 2; k++)
         send_request(OP_ADD, 8'(8'h10 + k), 32'd0, 4'd0);
      send_request(OP_ADD, 8'h77, 32'd1, 4'd0);
      send_request(OP_TICK, 8'd0, 32'd0, 4'd0);
      send_request(OP_REMOVE, 8'd0, 32'd0, 4'hF);
      send_request(OP_REMOVE, 8'd0, 32'd0, 4'd0);

      send_random();
      req_push <= 1'b0;

      while (table_shadow.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests accepted; responses checked: %0d fired, %0d added, %0d full,",
               table_shadow.requests, table_shadow.kind_seen[KIND_FIRED],
               table_shadow.kind_seen[KIND_ADDED], table_shadow.kind_seen[KIND_FULL]);
      $display("%0d removed, %0d invalid slot; %0d mismatches",
               table_shadow.kind_seen[KIND_REMOVED], table_shadow.kind_seen[KIND_BAD_SLOT],
               table_shadow.errors);
      if (table_shadow.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
